[hdl/tcfm_pkg.sv]
`timescale 1ns / 1ps

package tcfm_pkg;

    // phases of a frame on the two-wire bus
    typedef enum logic [3:0] {
        PH_IDLE    = 4'd0,
        PH_START_A = 4'd1,
        PH_START_B = 4'd2,
        PH_WLOW    = 4'd3,
        PH_WHIGH   = 4'd4,
        PH_ALOW    = 4'd5,
        PH_AHIGH   = 4'd6,
        PH_RLOW    = 4'd7,
        PH_RHIGH   = 4'd8,
        PH_MLOW    = 4'd9,
        PH_MHIGH   = 4'd10,
        PH_STOP_A  = 4'd11,
        PH_STOP_B  = 4'd12,
        PH_STOP_C  = 4'd13
    } phase_t;

    // line level bits: clock, data drive enable, data level
    localparam logic [2:0] LV_NONE = 3'b000;
    localparam logic [2:0] LV_SCL  = 3'b100;
    localparam logic [2:0] LV_EN   = 3'b010;
    localparam logic [2:0] LV_SDA  = 3'b001;

    // command bytes captured at frame start
    localparam int CMD_STORE_DEPTH = 4;
    localparam int BITS_PER_BYTE   = 8;

    // register map
    localparam logic REG_PHASE_LENGTH = 1'b0;
    localparam logic [15:0] PHASE_LENGTH_RESET = 16'd25;

    // one tick as seen by the engine
    typedef struct packed {
        logic       start_frame;
        logic       operation;
        logic [7:0] command_byte;
        logic [7:0] address_high;
        logic [7:0] address_low;
        logic [7:0] byte_count;
        logic [7:0] write_data;
        logic       sda_in;
    } tick_in_t;

    // result of one tick
    typedef struct packed {
        logic       scl_level;
        logic       sda_drive_enable;
        logic       sda_level;
        logic       busy_res;
        logic       write_data_taken;
        logic [7:0] read_data;
        logic       read_data_valid;
        logic       ack_missing;
        logic       frame_done;
    } tick_out_t;

endpackage

[hdl/two_wire_command_frame_master.sv]
`timescale 1ns / 1ps

// channel   direction  ports                         content
// s_        in         s_tvalid s_tready s_tdata     one clock tick with sampled data line
//                      s_tuser                       frame kind
// m_        out        m_tvalid m_tready m_tdata     line levels and status after the tick
// apb       in/out     psel penable pwrite paddr ... phase_length register
//
// One tick is taken every cycle unless m_tready holds the result register; each tick
// gives one result through the input register, then the result register after the frame step logic.
// Reset is synchronous and active low; it idles the bus with both lines high.
// A result that waits on m_tready holds the result register, and the input
// register keeps taking a tick as long as the result register is freed.

module two_wire_command_frame_master
    import tcfm_pkg::*;
#(
    parameter int COMMAND_LENGTH = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    // tick input
    input  logic        s_tvalid,
    output logic        s_tready,
    // start_frame[0], command_byte[8:1], address_high[16:9], address_low[24:17],
    // byte_count[32:25], write_data[40:33], sda_in[41], zero[47:42]
    input  logic [47:0] s_tdata,
    // operation[0]
    input  logic        s_tuser,
    // tick result
    output logic        m_tvalid,
    input  logic        m_tready,
    // scl_level[0], sda_drive_enable[1], sda_level[2], busy_res[3],
    // write_data_taken[4], read_data[12:5], read_data_valid[13],
    // ack_missing[14], frame_done[15]
    output logic [15:0] m_tdata,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic        in_valid_reg;
    tick_in_t    in_data_reg;
    logic        out_valid_reg;
    tick_out_t   out_data_reg;
    logic [15:0] phase_length_reg;
    logic        out_free;
    logic        step;
    tick_out_t   step_result;
    tick_in_t    in_unpacked;

    // register port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_PHASE_LENGTH) ? {16'd0, phase_length_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_length_reg <= PHASE_LENGTH_RESET;
        end else if (psel && penable && pwrite && paddr[2] == REG_PHASE_LENGTH) begin
            phase_length_reg <= pwdata[15:0];
        end
    end

    // input field unpacking
    assign in_unpacked.start_frame  = s_tdata[0];
    assign in_unpacked.operation    = s_tuser;
    assign in_unpacked.command_byte = s_tdata[8:1];
    assign in_unpacked.address_high = s_tdata[16:9];
    assign in_unpacked.address_low  = s_tdata[24:17];
    assign in_unpacked.byte_count   = s_tdata[32:25];
    assign in_unpacked.write_data   = s_tdata[40:33];
    assign in_unpacked.sda_in       = s_tdata[41];

    // pipeline flow control
    assign out_free = !out_valid_reg || m_tready;
    assign step     = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_data_reg <= in_unpacked;
        end
    end

    tcfm_engine #(
        .COMMAND_LENGTH (COMMAND_LENGTH)
    ) u_engine (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step         (step),
        .tick         (in_data_reg),
        .phase_length (phase_length_reg),
        .result       (step_result)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            out_data_reg <= step_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_data_reg.frame_done,
                       out_data_reg.ack_missing,
                       out_data_reg.read_data_valid,
                       out_data_reg.read_data,
                       out_data_reg.write_data_taken,
                       out_data_reg.busy_res,
                       out_data_reg.sda_level,
                       out_data_reg.sda_drive_enable,
                       out_data_reg.scl_level};

    // a finished frame leaves the bus idle with both lines high
    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_data_reg.frame_done) |->
        (!out_data_reg.busy_res && out_data_reg.scl_level && out_data_reg.sda_level))
        else $error("frame_done without idle bus");

    // a missing acknowledge is always followed by a stop, never ends the frame at once
    a_nack_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_data_reg.ack_missing) |->
        (out_data_reg.busy_res && !out_data_reg.scl_level))
        else $error("ack_missing outside a stop sequence");

    // a read byte and a data byte load never share one tick
    a_rx_tx_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> !(out_data_reg.read_data_valid && out_data_reg.write_data_taken))
        else $error("read and write data in the same tick");

    // an empty result register never blocks the input side
    a_no_bubble: assert property (@(posedge aclk) disable iff (!aresetn)
        !out_valid_reg |-> s_tready)
        else $error("input stalled with empty result register");

endmodule

[hdl/tcfm_engine.sv]
`timescale 1ns / 1ps

module tcfm_engine
    import tcfm_pkg::*;
#(
    parameter int COMMAND_LENGTH = 4
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      step,
    input  tick_in_t  tick,
    input  logic [15:0] phase_length,
    output tick_out_t result
);

    localparam int CMD_IDX_W = $clog2(COMMAND_LENGTH + 1);
    localparam logic [CMD_IDX_W-1:0] CMD_LAST = CMD_IDX_W'(COMMAND_LENGTH);

    phase_t             phase_reg, phase_next;
    logic [15:0]        timer_reg, timer_next;
    logic [3:0]         bitpos_reg, bitpos_next;
    logic [7:0]         remain_reg, remain_next;
    logic [7:0]         shift_reg, shift_next;
    logic               rx_mode_reg, rx_mode_next;
    logic [2:0]         levels_reg, levels_next;
    logic [CMD_IDX_W-1:0] cmd_idx_reg, cmd_idx_next;
    logic [7:0]         cmd_store [CMD_STORE_DEPTH];

    logic [15:0] plen_eff;
    logic [15:0] timer_dec;
    logic        phase_end;
    logic        go_data;
    logic [3:0]  idx_ext;
    logic [7:0]  next_cmd_byte;

    // zero phase length behaves as one
    assign plen_eff  = (phase_length == 16'd0) ? 16'd1 : phase_length;
    assign timer_dec = (timer_reg != 16'd0) ? timer_reg - 16'd1 : 16'd0;
    assign phase_end = (phase_reg != PH_IDLE) && (timer_dec == 16'd0);

    // command byte after the one just acknowledged, zero past the store
    assign idx_ext       = 4'(cmd_idx_reg + CMD_IDX_W'(1));
    assign next_cmd_byte = (idx_ext < 4'(CMD_STORE_DEPTH)) ? cmd_store[idx_ext[1:0]] : 8'd0;

    // next state and tick result
    always_comb begin
        phase_next   = phase_reg;
        timer_next   = timer_reg;
        bitpos_next  = bitpos_reg;
        remain_next  = remain_reg;
        shift_next   = shift_reg;
        rx_mode_next = rx_mode_reg;
        levels_next  = levels_reg;
        cmd_idx_next = cmd_idx_reg;
        go_data      = 1'b0;
        result       = '0;

        if (phase_reg == PH_IDLE) begin
            if (tick.start_frame) begin
                remain_next  = tick.byte_count;
                rx_mode_next = tick.operation;
                cmd_idx_next = '0;
                bitpos_next  = '0;
                phase_next   = PH_START_A;
                levels_next  = LV_SCL | LV_EN;
                timer_next   = plen_eff;
            end
        end else if (!phase_end) begin
            timer_next = timer_dec;
        end else begin
            timer_next = plen_eff;
            case (phase_reg)
                PH_START_A: begin
                    phase_next  = PH_START_B;
                    levels_next = LV_EN;
                end
                PH_START_B: begin
                    cmd_idx_next = '0;
                    shift_next   = cmd_store[0];
                    bitpos_next  = '0;
                    phase_next   = PH_WLOW;
                    levels_next  = LV_EN | {2'b00, cmd_store[0][7]};
                end
                PH_WLOW: begin
                    phase_next  = PH_WHIGH;
                    levels_next = LV_SCL | LV_EN | {2'b00, shift_reg[7]};
                end
                PH_WHIGH: begin
                    shift_next  = {shift_reg[6:0], 1'b0};
                    bitpos_next = bitpos_reg + 4'd1;
                    if (bitpos_next >= 4'(BITS_PER_BYTE)) begin
                        phase_next  = PH_ALOW;
                        levels_next = LV_SDA;
                    end else begin
                        phase_next  = PH_WLOW;
                        levels_next = LV_EN | {2'b00, shift_next[7]};
                    end
                end
                PH_ALOW: begin
                    phase_next  = PH_AHIGH;
                    levels_next = LV_SCL | LV_SDA;
                end
                PH_AHIGH: begin
                    if (tick.sda_in) begin
                        result.ack_missing = 1'b1;
                        phase_next  = PH_STOP_A;
                        levels_next = LV_EN;
                    end else if (cmd_idx_reg < CMD_LAST) begin
                        cmd_idx_next = cmd_idx_reg + CMD_IDX_W'(1);
                        if (cmd_idx_next < CMD_LAST) begin
                            shift_next  = next_cmd_byte;
                            bitpos_next = '0;
                            phase_next  = PH_WLOW;
                            levels_next = LV_EN | {2'b00, next_cmd_byte[7]};
                        end else begin
                            go_data = 1'b1;
                        end
                    end else begin
                        remain_next = remain_reg - 8'd1;
                        go_data     = 1'b1;
                    end
                end
                PH_RLOW: begin
                    phase_next  = PH_RHIGH;
                    levels_next = LV_SCL | LV_SDA;
                end
                PH_RHIGH: begin
                    shift_next  = {shift_reg[6:0], tick.sda_in};
                    bitpos_next = bitpos_reg + 4'd1;
                    if (bitpos_next >= 4'(BITS_PER_BYTE)) begin
                        result.read_data_valid = 1'b1;
                        result.read_data       = shift_next;
                        remain_next = remain_reg - 8'd1;
                        phase_next  = PH_MLOW;
                        levels_next = LV_EN | ((remain_next == 8'd0) ? LV_SDA : LV_NONE);
                    end else begin
                        phase_next  = PH_RLOW;
                        levels_next = LV_SDA;
                    end
                end
                PH_MLOW: begin
                    phase_next  = PH_MHIGH;
                    levels_next = levels_reg | LV_SCL;
                end
                PH_MHIGH: begin
                    go_data = 1'b1;
                end
                PH_STOP_A: begin
                    phase_next  = PH_STOP_B;
                    levels_next = LV_SCL | LV_EN;
                end
                PH_STOP_B: begin
                    phase_next  = PH_STOP_C;
                    levels_next = LV_SCL | LV_EN | LV_SDA;
                end
                default: begin
                    result.frame_done = 1'b1;
                    phase_next  = PH_IDLE;
                    levels_next = LV_SCL | LV_EN | LV_SDA;
                end
            endcase

            // next data byte, or the stop once the count is used up
            if (go_data) begin
                if (remain_next == 8'd0) begin
                    phase_next  = PH_STOP_A;
                    levels_next = LV_EN;
                end else if (rx_mode_reg) begin
                    shift_next  = '0;
                    bitpos_next = '0;
                    phase_next  = PH_RLOW;
                    levels_next = LV_SDA;
                end else begin
                    result.write_data_taken = 1'b1;
                    shift_next  = tick.write_data;
                    bitpos_next = '0;
                    phase_next  = PH_WLOW;
                    levels_next = LV_EN | {2'b00, tick.write_data[7]};
                end
            end
        end

        result.scl_level        = levels_next[2];
        result.sda_drive_enable = levels_next[1];
        result.sda_level        = levels_next[0];
        result.busy_res         = (phase_next != PH_IDLE);
    end

    // frame state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_IDLE;
            timer_reg   <= '0;
            bitpos_reg  <= '0;
            remain_reg  <= '0;
            shift_reg   <= '0;
            rx_mode_reg <= 1'b0;
            levels_reg  <= LV_SCL | LV_EN | LV_SDA;
            cmd_idx_reg <= '0;
        end else if (step) begin
            phase_reg   <= phase_next;
            timer_reg   <= timer_next;
            bitpos_reg  <= bitpos_next;
            remain_reg  <= remain_next;
            shift_reg   <= shift_next;
            rx_mode_reg <= rx_mode_next;
            levels_reg  <= levels_next;
            cmd_idx_reg <= cmd_idx_next;
        end
    end

    // command bytes, written when a frame starts
    always_ff @(posedge aclk) begin
        if (step && phase_reg == PH_IDLE && tick.start_frame) begin
            cmd_store[0] <= tick.command_byte;
            cmd_store[1] <= tick.address_high;
            cmd_store[2] <= tick.address_low;
            cmd_store[3] <= tick.byte_count;
        end
    end

endmodule

[bench/two_wire_command_frame_master_tb.sv]
`timescale 1ns / 1ps

module two_wire_command_frame_master_tb;
    import tcfm_pkg::*;

    localparam int COMMAND_LENGTH = 4;
    localparam int STUCK_LIMIT    = 4000;
    localparam int LONG_HOLD      = 400;
    localparam int PHASE_TICKS    = 200;
    localparam int RANDOM_TICKS   = 700;
    localparam int TAIL_CYCLES    = 20;

    // state of the bus engine as the testbench tracks it
    typedef struct {
        phase_t          phase;
        logic [15:0]     timer;
        logic [3:0]      bit_cnt;
        logic [7:0]      left;
        logic [7:0]      shifter;
        logic [3:0][7:0] cmd;
        logic            rx;
        logic [2:0]      lines;
        int              cmd_idx;
    } bus_state_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata  = '0;
    logic        s_tuser  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    // phase length as currently programmed; shared by stimulus and prediction
    logic [15:0] phase_len = PHASE_LENGTH_RESET;

    bus_state_t  stim_bus;
    bus_state_t  pred_bus;
    tick_in_t    pending_ticks[$];
    tick_out_t   predicted_results[$];

    int          ticks_queued    = 0;
    int          ticks_accepted  = 0;
    int          results_checked = 0;
    int          mismatch_count  = 0;
    int          frames_done     = 0;
    int          bytes_read      = 0;
    int          bytes_sent      = 0;
    int          acks_missed     = 0;

    // stimulus shaping
    int          nack_at     = -1;
    int          acks_seen   = 0;
    int          fixed_wdata = -1;
    int          tx_gap_mode = 1;
    int          rx_gap_mode = 1;
    int          tx_gap_left = 0;
    int          rx_stall_left = 0;
    int          hold_left   = 0;
    logic        hold_request = 1'b0;
    logic        hold_served  = 1'b0;
    logic        tick_taken   = 1'b0;
    int          stuck_cycles = 0;

    tick_in_t    drive_tick;
    tick_in_t    seen_tick;
    tick_out_t   got;
    tick_out_t   want;

    two_wire_command_frame_master #(.COMMAND_LENGTH(COMMAND_LENGTH)) u_top (.*);

    always #2 aclk = ~aclk;

    // ---------------------------------------------------------------- bus engine prediction

    function automatic void enter_phase(inout bus_state_t e, input phase_t ph,
                                        input logic [2:0] lv);
        e.phase = ph;
        e.lines = lv;
        e.timer = (phase_len == 16'd0) ? 16'd1 : phase_len;
    endfunction

    function automatic void drive_bit(inout bus_state_t e, input phase_t ph);
        enter_phase(e, ph, ((ph == PH_WHIGH) ? LV_SCL : LV_NONE) | LV_EN
                           | {2'b00, e.shifter[7]});
    endfunction

    function automatic void load_byte(inout bus_state_t e, input logic [7:0] value);
        e.shifter = value;
        e.bit_cnt = '0;
        drive_bit(e, PH_WLOW);
    endfunction

    // next data byte or the stop; returns 1 when a send byte is taken
    function automatic logic open_data(inout bus_state_t e);
        if (e.left == 8'd0) begin
            enter_phase(e, PH_STOP_A, LV_EN);
            return 1'b0;
        end
        if (e.rx) begin
            e.shifter = '0;
            e.bit_cnt = '0;
            enter_phase(e, PH_RLOW, LV_SDA);
            return 1'b0;
        end
        load_byte(e, 8'h00);
        return 1'b1;
    endfunction

    // advance the engine by one tick and give the line levels and flags after it
    function automatic tick_out_t bus_step(inout bus_state_t e, input tick_in_t t);
        tick_out_t r;
        logic      taken;
        r     = '0;
        taken = 1'b0;
        if (e.phase == PH_IDLE) begin
            if (t.start_frame) begin
                e.cmd     = {t.byte_count, t.address_low, t.address_high, t.command_byte};
                e.left    = t.byte_count;
                e.rx      = t.operation;
                e.cmd_idx = 0;
                e.bit_cnt = '0;
                enter_phase(e, PH_START_A, LV_SCL | LV_EN);
            end
        end else begin
            if (e.timer != 16'd0)
                e.timer--;
            if (e.timer == 16'd0) begin
                case (e.phase)
                    PH_START_A: enter_phase(e, PH_START_B, LV_EN);
                    PH_START_B: begin
                        e.cmd_idx = 0;
                        load_byte(e, e.cmd[0]);
                    end
                    PH_WLOW: drive_bit(e, PH_WHIGH);
                    PH_WHIGH: begin
                        e.shifter = e.shifter << 1;
                        e.bit_cnt++;
                        if (e.bit_cnt >= 4'd8)
                            enter_phase(e, PH_ALOW, LV_SDA);
                        else
                            drive_bit(e, PH_WLOW);
                    end
                    PH_ALOW: enter_phase(e, PH_AHIGH, LV_SCL | LV_SDA);
                    PH_AHIGH: begin
                        if (t.sda_in) begin
                            r.ack_missing = 1'b1;
                            enter_phase(e, PH_STOP_A, LV_EN);
                        end else if (e.cmd_idx < COMMAND_LENGTH) begin
                            e.cmd_idx++;
                            if (e.cmd_idx < COMMAND_LENGTH)
                                load_byte(e, e.cmd[e.cmd_idx]);
                            else
                                taken = open_data(e);
                        end else begin
                            e.left--;
                            taken = open_data(e);
                        end
                        if (taken)
                            load_byte(e, t.write_data);
                    end
                    PH_RLOW: enter_phase(e, PH_RHIGH, LV_SCL | LV_SDA);
                    PH_RHIGH: begin
                        e.shifter = {e.shifter[6:0], t.sda_in};
                        e.bit_cnt++;
                        if (e.bit_cnt >= 4'd8) begin
                            r.read_data_valid = 1'b1;
                            r.read_data       = e.shifter;
                            e.left--;
                            enter_phase(e, PH_MLOW,
                                        LV_EN | ((e.left == 8'd0) ? LV_SDA : LV_NONE));
                        end else begin
                            enter_phase(e, PH_RLOW, LV_SDA);
                        end
                    end
                    PH_MLOW: enter_phase(e, PH_MHIGH, e.lines | LV_SCL);
                    PH_MHIGH: taken = open_data(e);
                    PH_STOP_A: enter_phase(e, PH_STOP_B, LV_SCL | LV_EN);
                    PH_STOP_B: enter_phase(e, PH_STOP_C, LV_SCL | LV_EN | LV_SDA);
                    default: begin
                        r.frame_done = 1'b1;
                        enter_phase(e, PH_IDLE, LV_SCL | LV_EN | LV_SDA);
                    end
                endcase
            end
        end
        r.scl_level        = e.lines[2];
        r.sda_drive_enable = e.lines[1];
        r.sda_level        = e.lines[0];
        r.busy_res         = (e.phase != PH_IDLE);
        r.write_data_taken = taken;
        return r;
    endfunction

    // ---------------------------------------------------------------- stimulus

    function automatic int pick_gap(input int mode);
        int r;
        r = $urandom_range(0, 99);
        if (mode == 0 || r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic tick_in_t random_tick();
        tick_in_t t;
        t.start_frame  = 1'($urandom_range(0, 1));
        t.operation    = 1'($urandom_range(0, 1));
        t.command_byte = 8'($urandom);
        t.address_high = 8'($urandom);
        t.address_low  = 8'($urandom);
        t.byte_count   = 8'($urandom);
        t.write_data   = 8'($urandom);
        t.sda_in       = 1'($urandom_range(0, 1));
        return t;
    endfunction

    task automatic push_tick(input tick_in_t t);
        void'(bus_step(stim_bus, t));
        pending_ticks.push_back(t);
        ticks_queued++;
    endtask

    task automatic queue_idle(input int n);
        tick_in_t t;
        for (int i = 0; i < n; i++) begin
            t = random_tick();
            t.start_frame = 1'b0;
            push_tick(t);
        end
    endtask

    task automatic open_frame(input logic op, input logic [7:0] opcode, addr_hi, addr_lo,
                              count, input int nack, input int wpat);
        tick_in_t t;
        t = random_tick();
        t.start_frame  = 1'b1;
        t.operation    = op;
        t.command_byte = opcode;
        t.address_high = addr_hi;
        t.address_low  = addr_lo;
        t.byte_count   = count;
        nack_at     = nack;
        acks_seen   = 0;
        fixed_wdata = wpat;
        push_tick(t);
    endtask

    // ticks of a running frame: acknowledges low unless a missing one is planned
    task automatic run_frame(input int max_ticks);
        tick_in_t t;
        int       n;
        n = 0;
        while (stim_bus.phase != PH_IDLE && n < max_ticks) begin
            t = random_tick();
            if (stim_bus.phase == PH_AHIGH && stim_bus.timer == 16'd1) begin
                t.sda_in = (acks_seen == nack_at);
                acks_seen++;
            end
            if (fixed_wdata >= 0)
                t.write_data = fixed_wdata[7:0];
            push_tick(t);
            n++;
        end
    endtask

    task automatic queue_frame(input logic op, input logic [7:0] opcode, addr_hi, addr_lo,
                               count, input int nack, input int wpat);
        open_frame(op, opcode, addr_hi, addr_lo, count, nack, wpat);
        run_frame(32'h7fff_ffff);
    endtask

    task automatic queue_random_frame();
        logic op;
        int   pick;
        int   count;
        int   nack;
        op   = 1'($urandom_range(0, 1));
        pick = $urandom_range(0, 99);
        if (pick < 70)
            count = $urandom_range(0, 3);
        else
            count = $urandom_range(4, 8);
        nack = ($urandom_range(0, 4) == 0) ? $urandom_range(0, op ? 3 : 3 + count) : -1;
        queue_frame(op, 8'($urandom), 8'($urandom), 8'($urandom), 8'(count), nack, -1);
        queue_idle($urandom_range(0, 4));
    endtask

    // every queued tick accepted and every result back
    task automatic wait_drained();
        while (ticks_accepted != ticks_queued || predicted_results.size() != 0)
            @(negedge aclk);
    endtask

    task automatic write_phase_length(input logic [15:0] value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 3'(4 * int'(REG_PHASE_LENGTH));
        pwdata  <= {16'h0000, value};
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        phase_len = value;
    endtask

    // ---------------------------------------------------------------- sequence

    initial begin
        int phase_no;
        int random_ticks;
        int phase_start;
        int pick;
        pred_bus.phase   = PH_IDLE;
        pred_bus.timer   = '0;
        pred_bus.bit_cnt = '0;
        pred_bus.left    = '0;
        pred_bus.shifter = '0;
        pred_bus.cmd     = '0;
        pred_bus.rx      = 1'b0;
        pred_bus.lines   = LV_SCL | LV_EN | LV_SDA;
        pred_bus.cmd_idx = 0;
        stim_bus = pred_bus;

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset value of the phase length, then a shorter one set mid-frame
        open_frame(1'b0, 8'hFF, 8'h00, 8'hFF, 8'd1, -1, 8'hA5);
        run_frame(12);
        wait_drained();
        write_phase_length(16'd2);
        run_frame(32'h7fff_ffff);
        queue_idle(2);
        wait_drained();

        // shortest phases: zero counts, fixed data, missing acks, largest counts
        write_phase_length(16'd1);
        queue_frame(1'b0, 8'h00, 8'hFF, 8'h00, 8'd0, -1, -1);
        queue_frame(1'b1, 8'hFF, 8'hFF, 8'hFF, 8'd0, -1, -1);
        queue_frame(1'b0, 8'h5A, 8'h01, 8'h80, 8'd2, -1, 8'h00);
        queue_frame(1'b0, 8'hA5, 8'h80, 8'h01, 8'd2, -1, 8'hFF);
        queue_frame(1'b1, 8'h3C, 8'h12, 8'h34, 8'd3, -1, -1);
        queue_frame(1'b0, 8'h11, 8'h22, 8'h33, 8'd3, 0, -1);
        queue_frame(1'b0, 8'h44, 8'h55, 8'h66, 8'd3, 5, -1);
        queue_frame(1'b1, 8'h77, 8'h88, 8'h99, 8'd2, 3, -1);
        queue_frame(1'b1, 8'hC3, 8'hFF, 8'h00, 8'd255, 3, -1);
        queue_frame(1'b0, 8'h00, 8'h00, 8'hFF, 8'd255, 6, -1);
        queue_idle(3);
        wait_drained();

        // zero phase length behaves as one
        write_phase_length(16'd0);
        queue_frame(1'b1, 8'hE7, 8'h0F, 8'hF0, 8'd1, -1, -1);
        wait_drained();

        // random frames over short phase lengths, idling switched per phase
        phase_no     = 0;
        random_ticks = 0;
        while (random_ticks < RANDOM_TICKS) begin
            pick = $urandom_range(0, 4);
            write_phase_length(pick < 3 ? 16'd1 : 16'd2);
            tx_gap_mode = (phase_no % 3 != 2);
            rx_gap_mode = (phase_no % 4 != 3);
            phase_start = ticks_queued;
            while (ticks_queued - phase_start < PHASE_TICKS)
                queue_random_frame();
            if (phase_no == 1)
                hold_request = 1'b1;
            random_ticks += ticks_queued - phase_start;
            phase_no++;
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(negedge aclk);
        $display("covered %0d ticks in %0d frames: %0d bytes read, %0d bytes sent, %0d nacks",
                 results_checked, frames_done, bytes_read, bytes_sent, acks_missed);
        $display("phase lengths 25 then 2 mid-frame, 1, 0 and random 1 or 2; %0d mismatches",
                 mismatch_count);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // ---------------------------------------------------------------- tick driver

    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || tick_taken) begin
            if (tx_gap_left > 0) begin
                s_tvalid <= 1'b0;
                tx_gap_left--;
            end else if (pending_ticks.size() != 0) begin
                drive_tick = pending_ticks.pop_front();
                s_tdata  <= {6'b0, drive_tick.sda_in, drive_tick.write_data,
                             drive_tick.byte_count, drive_tick.address_low,
                             drive_tick.address_high, drive_tick.command_byte,
                             drive_tick.start_frame};
                s_tuser  <= drive_tick.operation;
                s_tvalid <= 1'b1;
                tx_gap_left = pick_gap(tx_gap_mode);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------- result receiver

    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (hold_request && !hold_served) begin
                hold_left   = LONG_HOLD;
                hold_served = 1'b1;
            end
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else if (rx_stall_left > 0) begin
                m_tready <= 1'b0;
                rx_stall_left--;
            end else begin
                m_tready <= 1'b1;
                rx_stall_left = pick_gap(rx_gap_mode);
            end
        end
    end

    // ---------------------------------------------------------------- monitor and checker

    task automatic report_mismatch(input string msg);
        $display("mismatch at result %0d: %s", results_checked, msg);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic [7:0] seen,
                               input logic [7:0] predicted);
        if (seen !== predicted)
            report_mismatch($sformatf("%s got %0h want %0h", name, seen, predicted));
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            tick_taken <= 1'b0;
        end else begin
            tick_taken <= s_tvalid && s_tready;

            // input transaction: step the prediction
            if (s_tvalid && s_tready) begin
                seen_tick.start_frame  = s_tdata[0];
                seen_tick.command_byte = s_tdata[8:1];
                seen_tick.address_high = s_tdata[16:9];
                seen_tick.address_low  = s_tdata[24:17];
                seen_tick.byte_count   = s_tdata[32:25];
                seen_tick.write_data   = s_tdata[40:33];
                seen_tick.sda_in       = s_tdata[41];
                seen_tick.operation    = s_tuser;
                predicted_results.push_back(bus_step(pred_bus, seen_tick));
                ticks_accepted++;
            end

            // result transaction: compare with the oldest prediction
            if (m_tvalid && m_tready) begin
                got.scl_level        = m_tdata[0];
                got.sda_drive_enable = m_tdata[1];
                got.sda_level        = m_tdata[2];
                got.busy_res         = m_tdata[3];
                got.write_data_taken = m_tdata[4];
                got.read_data        = m_tdata[12:5];
                got.read_data_valid  = m_tdata[13];
                got.ack_missing      = m_tdata[14];
                got.frame_done       = m_tdata[15];
                if (predicted_results.size() == 0) begin
                    report_mismatch("result with no tick waiting");
                end else begin
                    want = predicted_results.pop_front();
                    check_field("scl_level", {7'd0, got.scl_level}, {7'd0, want.scl_level});
                    check_field("sda_drive_enable", {7'd0, got.sda_drive_enable},
                                {7'd0, want.sda_drive_enable});
                    check_field("sda_level", {7'd0, got.sda_level}, {7'd0, want.sda_level});
                    check_field("busy_res", {7'd0, got.busy_res}, {7'd0, want.busy_res});
                    check_field("write_data_taken", {7'd0, got.write_data_taken},
                                {7'd0, want.write_data_taken});
                    check_field("read_data", got.read_data, want.read_data);
                    check_field("read_data_valid", {7'd0, got.read_data_valid},
                                {7'd0, want.read_data_valid});
                    check_field("ack_missing", {7'd0, got.ack_missing},
                                {7'd0, want.ack_missing});
                    check_field("frame_done", {7'd0, got.frame_done}, {7'd0, want.frame_done});
                    frames_done += want.frame_done;
                    bytes_read  += want.read_data_valid;
                    bytes_sent  += want.write_data_taken;
                    acks_missed += want.ack_missing;
                end
                results_checked++;
            end
        end
    end

    // ---------------------------------------------------------------- watchdog

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                stuck_cycles = 0;
            end else begin
                stuck_cycles++;
                if (stuck_cycles >= STUCK_LIMIT) begin
                    $display("timeout: no transaction for %0d cycles", STUCK_LIMIT);
                    $display("end of test: mismatches");
                    $finish;
                end
            end
        end
    end

endmodule

[sim.f]
hdl/tcfm_pkg.sv
hdl/tcfm_engine.sv
hdl/two_wire_command_frame_master.sv
bench/two_wire_command_frame_master_tb.sv
